FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a
// consequent. The reset disables the check while it is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in the following cycle");

`endif

FILE: design/svcsel_pkg.sv
`timescale 1ns / 1ps

package svcsel_pkg;

  localparam int unsigned LayerW = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  typedef logic [LayerW-1:0] layer_t;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic {
    REG_TARGET_TEMPORAL = 1'b0,
    REG_TARGET_SPATIAL  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic   present;
    layer_t tid;
    layer_t sid;
    logic   switch_pt;
    logic   frame_start;
    logic   frame_end;
    logic   inter;
    logic   marker;
  } pkt_t;

  typedef struct packed {
    layer_t cur_temporal;
    layer_t cur_spatial;
    logic   await_intra;
  } sel_state_t;

  typedef struct packed {
    logic fwd;
    logic marker;
  } sel_result_t;

endpackage

FILE: design/svcsel_decide.sv
`timescale 1ns / 1ps

module svcsel_decide
  import svcsel_pkg::*;
(
  input  pkt_t        pkt_i,
  input  sel_state_t  state_i,
  input  layer_t      tgt_temporal_i,
  input  layer_t      tgt_spatial_i,
  output sel_state_t  state_o,
  output sel_result_t result_o
);

  layer_t eff_t;
  layer_t eff_s;
  layer_t next_t;
  layer_t next_s;
  logic   t_drop;
  logic   s_drop;
  logic   intra_drop;

  // Temporal layer: climb only at a switching point on a frame start,
  // step down to the packet's layer at a frame end.
  always_comb begin
    eff_t  = state_i.cur_temporal;
    next_t = state_i.cur_temporal;
    if (tgt_temporal_i > state_i.cur_temporal) begin
      if (pkt_i.switch_pt && pkt_i.frame_start && (state_i.cur_temporal < pkt_i.tid) &&
          (pkt_i.tid <= tgt_temporal_i)) begin
        next_t = pkt_i.tid;
        eff_t  = pkt_i.tid;
      end
    end else if (tgt_temporal_i < state_i.cur_temporal) begin
      if (pkt_i.frame_end) begin
        next_t = pkt_i.tid;
      end
    end
  end

  assign t_drop = pkt_i.tid > eff_t;

  // Spatial layer: up only on an intra frame start, down at a frame end.
  always_comb begin
    eff_s  = state_i.cur_spatial;
    next_s = state_i.cur_spatial;
    if (tgt_spatial_i > state_i.cur_spatial) begin
      if (!pkt_i.inter && pkt_i.frame_start && (state_i.cur_spatial < pkt_i.sid) &&
          (pkt_i.sid <= tgt_spatial_i)) begin
        next_s = pkt_i.sid;
        eff_s  = pkt_i.sid;
      end
    end else if (tgt_spatial_i < state_i.cur_spatial) begin
      if (pkt_i.frame_end) begin
        next_s = pkt_i.sid;
      end
    end
  end

  assign s_drop     = pkt_i.sid > eff_s;
  assign intra_drop = state_i.await_intra && pkt_i.inter;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (pkt_i.present) begin
      state_o.cur_temporal = next_t;
      if (!t_drop) begin
        state_o.cur_spatial = next_s;
        if (!s_drop) begin
          if (!intra_drop) begin
            state_o.await_intra = 1'b0;
            result_o.fwd        = 1'b1;
            result_o.marker     = pkt_i.marker ||
                                  (pkt_i.frame_end && (next_s == pkt_i.sid) &&
                                   (tgt_spatial_i <= next_s));
          end
        end
      end
    end
  end

endmodule

FILE: design/svc_layer_packet_selector.sv
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// input     | in_valid_i / in_stall_o    | descriptor_present_i .. incoming_marker_i
// output    | out_valid_o / out_stall_i  | forward_o, out_marker_o
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata (2 regs, 4 bytes apart)
//
// Every packet passes through the input register and then moves to the result
// register, which offers its result until the output takes it. One packet is
// taken per cycle while the output keeps taking results; the layer state
// updates in one pass of logic.
// Reset clears the targets and current layers and sets the wait-for-intra flag.
// A stall on the output stalls the input only once both registers are full.

module svc_layer_packet_selector
  import svcsel_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             descriptor_present_i,
  input  logic [LayerW-1:0] pkt_temporal_layer_i,
  input  logic [LayerW-1:0] pkt_spatial_layer_i,
  input  logic             switching_point_i,
  input  logic             layer_frame_start_i,
  input  logic             layer_frame_end_i,
  input  logic             inter_predicted_i,
  input  logic             incoming_marker_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             forward_o,
  output logic             out_marker_o,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // Configuration registers. The word address picks the register; the low
  // three bits of the write data are kept.
  layer_t   tgt_temporal_q;
  layer_t   tgt_spatial_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_temporal_q <= '0;
      tgt_spatial_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TARGET_TEMPORAL: tgt_temporal_q <= pwdata[LayerW-1:0];
        REG_TARGET_SPATIAL:  tgt_spatial_q  <= pwdata[LayerW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_TARGET_TEMPORAL: prdata = {{(DataW-LayerW){1'b0}}, tgt_temporal_q};
      REG_TARGET_SPATIAL:  prdata = {{(DataW-LayerW){1'b0}}, tgt_spatial_q};
      default:             prdata = '0;
    endcase
  end

  // Input register. It refills whenever its packet moves on, so packets
  // flow one per cycle while the output side keeps taking results.
  logic        in_valid_q;
  pkt_t        pkt_q;
  logic        advance;
  logic        in_take;

  logic        out_valid_q;
  sel_result_t result_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pkt_q.present     <= descriptor_present_i;
      pkt_q.tid         <= pkt_temporal_layer_i;
      pkt_q.sid         <= pkt_spatial_layer_i;
      pkt_q.switch_pt   <= switching_point_i;
      pkt_q.frame_start <= layer_frame_start_i;
      pkt_q.frame_end   <= layer_frame_end_i;
      pkt_q.inter       <= inter_predicted_i;
      pkt_q.marker      <= incoming_marker_i;
    end
  end

  // Layer state: committed as the packet in the input register is decided.
  sel_state_t  state_q;
  sel_state_t  state_d;
  sel_result_t result_d;

  svcsel_decide u_decide (
    .pkt_i          (pkt_q),
    .state_i        (state_q),
    .tgt_temporal_i (tgt_temporal_q),
    .tgt_spatial_i  (tgt_spatial_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur_temporal <= '0;
      state_q.cur_spatial  <= '0;
      state_q.await_intra  <= 1'b1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register. It holds its result while the output is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign forward_o    = result_q.fwd;
  assign out_marker_o = result_q.marker;

endmodule

FILE: design/svcsel_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module svcsel_checker
  import svcsel_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic forward_o,
  input logic out_marker_o
);

  // A stalled result stays on offer.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A dropped packet never carries a marker.
  `ASSERT_SAME(a_marker_fwd, clk_i, rst_ni, out_valid_o && !forward_o, !out_marker_o)

  // The input is held back only when a result is waiting and stalled.
  `ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind svc_layer_packet_selector svcsel_checker u_svcsel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .forward_o    (forward_o),
  .out_marker_o (out_marker_o)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the scalable-video layer packet selector.
//
// Packets are pushed into the input channel one transfer at a time. On every
// accepted transfer the bench runs its own copy of the selection rules
// (current layers, target layers and the wait-for-intra flag) and queues the
// expected forward decision and marker bit. A separate process pops that
// queue on every output transfer and compares field by field.
//
// The run is split into named tests: a directed walk through the reset state,
// the up-switch rules, the down-switch rules, a long receiver hold-off and
// then random traffic built mostly from well-formed layer frames. Target
// registers are only written through the configuration port while the block
// is empty, and every write is read back.

module testbench
  import svcsel_pkg::*;
();

  localparam int unsigned LongHoldCycles = 60;
  localparam int unsigned DrainCycles    = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;

  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             descriptor_present_i = 1'b0;
  logic [LayerW-1:0] pkt_temporal_layer_i = '0;
  logic [LayerW-1:0] pkt_spatial_layer_i = '0;
  logic             switching_point_i = 1'b0;
  logic             layer_frame_start_i = 1'b0;
  logic             layer_frame_end_i = 1'b0;
  logic             inter_predicted_i = 1'b0;
  logic             incoming_marker_i = 1'b0;

  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             forward_o;
  logic             out_marker_o;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  svc_layer_packet_selector u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .descriptor_present_i (descriptor_present_i),
    .pkt_temporal_layer_i (pkt_temporal_layer_i),
    .pkt_spatial_layer_i  (pkt_spatial_layer_i),
    .switching_point_i    (switching_point_i),
    .layer_frame_start_i  (layer_frame_start_i),
    .layer_frame_end_i    (layer_frame_end_i),
    .inter_predicted_i    (inter_predicted_i),
    .incoming_marker_i    (incoming_marker_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .forward_o            (forward_o),
    .out_marker_o         (out_marker_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // Selector state as the bench believes it to be, plus the target layers
  // last written through the configuration port.
  sel_state_t    sel_state;
  layer_t        tgt_temporal;
  layer_t        tgt_spatial;

  // Expected results, oldest first.
  sel_result_t   pending_results[$];

  int unsigned   mismatch_count = 0;
  int unsigned   packets_sent = 0;

  // Idle controls. The sender and receiver each insert random gaps while
  // their flag is set; the final stretch runs with both switched off.
  bit            sender_gaps = 1'b0;
  bit            receiver_gaps = 1'b0;
  bit            long_hold_req = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Generous fixed limit. The slowest legal run is roughly 1100 packets that
  // each see the longest sender gap and the longest receiver stall; this
  // allows more than ten times that run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Decide one packet the way the selector should, updating the tracked
  // state. Layer moves made while examining the packet stick even when the
  // packet is then dropped.
  function automatic sel_result_t select_packet(input pkt_t p);
    sel_result_t r;
    layer_t      eff;
    r = '0;
    if (!p.present) return r;

    // Temporal layer: up only at a switching point on a frame start, down
    // only on a frame end and then to the packet's own layer id.
    eff = sel_state.cur_temporal;
    if (tgt_temporal > sel_state.cur_temporal) begin
      if (p.switch_pt && p.frame_start && eff < p.tid && p.tid <= tgt_temporal) begin
        sel_state.cur_temporal = p.tid;
        eff = p.tid;
      end
    end else if (tgt_temporal < sel_state.cur_temporal) begin
      if (p.frame_end) sel_state.cur_temporal = p.tid;
    end
    if (p.tid > eff) return r;

    // Spatial layer: up only on an intra frame start, down only on a frame end.
    eff = sel_state.cur_spatial;
    if (tgt_spatial > sel_state.cur_spatial) begin
      if (!p.inter && p.frame_start && eff < p.sid && p.sid <= tgt_spatial) begin
        sel_state.cur_spatial = p.sid;
        eff = p.sid;
      end
    end else if (tgt_spatial < sel_state.cur_spatial) begin
      if (p.frame_end) sel_state.cur_spatial = p.sid;
    end
    if (p.sid > eff) return r;

    if (sel_state.await_intra) begin
      if (p.inter) return r;
      sel_state.await_intra = 1'b0;
    end

    r.fwd    = 1'b1;
    r.marker = p.marker || (p.frame_end && sel_state.cur_spatial == p.sid &&
                            tgt_spatial <= sel_state.cur_spatial);
    return r;
  endfunction

  // Receiver side: random stall bursts, or one long hold-off on request.
  // The hold-off length is counted here so the sender can keep offering.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker. Values are sampled at the edge, before any of this
  // edge's updates land, so the handshake is seen as the block sees it.
  always @(posedge clk_i) begin
    sel_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: forward=%0b out_marker=%0b",
               forward_o, out_marker_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (forward_o !== exp_r.fwd) begin
          $error("forward: expected %0b, actual %0b", exp_r.fwd, forward_o);
          mismatch_count++;
        end
        if (out_marker_o !== exp_r.marker) begin
          $error("out_marker: expected %0b, actual %0b", exp_r.marker, out_marker_o);
          mismatch_count++;
        end
      end
    end
  end

  // One configuration port access: setup cycle, then access cycle(s) until
  // pready. A read hands back prdata as sampled at the completing edge.
  task automatic apb_access(input bit is_write, input reg_idx_e idx,
                            input logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a target register with junk in the unused upper bits, mirror it in
  // the predictor and read it back.
  task automatic set_target(input reg_idx_e idx, input layer_t val);
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] rdata;
    wdata = {$urandom()};
    wdata[LayerW-1:0] = val;
    apb_access(1'b1, idx, wdata, rdata);
    if (idx == REG_TARGET_TEMPORAL) tgt_temporal = val;
    else tgt_spatial = val;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata[LayerW-1:0] !== val) begin
      $error("register %s readback: expected %0d, actual %0d",
             idx.name(), val, rdata[LayerW-1:0]);
      mismatch_count++;
    end
  endtask

  // Let every outstanding result come out, then give the pipeline a further
  // DrainCycles wait before anything touches the registers.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_targets(input layer_t t_val, input layer_t s_val);
    drain_results();
    set_target(REG_TARGET_TEMPORAL, t_val);
    set_target(REG_TARGET_SPATIAL, s_val);
  endtask

  // Offer one packet and hold it until the transfer happens. An optional
  // random gap goes in front of it.
  task automatic send_packet(input pkt_t p);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    descriptor_present_i <= p.present;
    pkt_temporal_layer_i <= p.tid;
    pkt_spatial_layer_i  <= p.sid;
    switching_point_i    <= p.switch_pt;
    layer_frame_start_i  <= p.frame_start;
    layer_frame_end_i    <= p.frame_end;
    inter_predicted_i    <= p.inter;
    incoming_marker_i    <= p.marker;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(select_packet(p));
    packets_sent++;
  endtask

  // Shorthand for directed packets with a descriptor present.
  task automatic send_desc(input layer_t tid, input layer_t sid, input bit sw,
                           input bit start, input bit fin, input bit inter,
                           input bit marker);
    pkt_t p;
    p = '{present: 1'b1, tid: tid, sid: sid, switch_pt: sw, frame_start: start,
          frame_end: fin, inter: inter, marker: marker};
    send_packet(p);
  endtask

  // Reset state: targets 0 and waiting for intra. Predicted frames are held
  // back until the first intra packet; a packet without a descriptor is
  // always dropped.
  task automatic test_reset_and_intra_wait();
    pkt_t p;
    p = '1;
    p.present = 1'b0;
    send_packet(p);
    send_desc(3'd0, 3'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_desc(3'd0, 3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_desc(3'd1, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    send_desc(3'd0, 3'd1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    send_desc(3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    drain_results();
  endtask

  // Targets at the top. Temporal moves up only at switching points on a
  // frame start; when the temporal test drops a packet the spatial layer must
  // stay where it was; spatial moves up only on intra frame starts.
  task automatic test_up_switch();
    set_targets(3'd7, 3'd7);
    send_desc(3'd3, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    send_desc(3'd5, 3'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_desc(3'd0, 3'd2, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_desc(3'd0, 3'd2, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_desc(3'd7, 3'd7, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_desc(3'd7, 3'd7, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    drain_results();
  endtask

  // Targets at the bottom with the current layers at the top. A down-switch
  // takes the packet's own layer id, which can even move the layer up, and
  // the move sticks although the packet itself is dropped.
  task automatic test_down_switch();
    set_targets(3'd0, 3'd0);
    send_desc(3'd4, 3'd5, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_desc(3'd2, 3'd3, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_desc(3'd3, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_desc(3'd0, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_desc(3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    drain_results();
  endtask

  function automatic pkt_t random_packet();
    pkt_t p;
    p = pkt_t'($urandom());
    p.present = ($urandom_range(0, 7) != 0);
    return p;
  endfunction

  // One layer frame of one to four packets. Now and then the first packet
  // goes missing so the frame starts without its start flag.
  task automatic send_layer_frame(input layer_t tid, input layer_t sid, input bit sw,
                                  input bit inter, input bit top_layer);
    int unsigned n_pkts;
    pkt_t        p;
    n_pkts = $urandom_range(1, 4);
    for (int unsigned k = 0; k < n_pkts; k++) begin
      if (k == 0 && n_pkts > 1 && $urandom_range(0, 19) == 0) continue;
      p.present     = 1'b1;
      p.tid         = tid;
      p.sid         = sid;
      p.switch_pt   = sw;
      p.frame_start = (k == 0);
      p.frame_end   = (k == n_pkts - 1);
      p.inter       = inter;
      p.marker      = top_layer && p.frame_end && ($urandom_range(0, 3) != 0);
      send_packet(p);
    end
  endtask

  // A picture across its spatial layers. Key pictures sit on temporal layer 0
  // with an intra base layer; the rest are mostly predicted.
  task automatic send_picture(input bit key);
    layer_t      tid;
    int unsigned n_spatial;
    bit          sw;
    bit          inter;
    tid = key ? 3'd0 : layer_t'($urandom_range(0, 7) >> $urandom_range(0, 2));
    n_spatial = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
    sw = ($urandom_range(0, 3) != 0);
    for (int unsigned s = 0; s < n_spatial; s++) begin
      if (key) inter = (s == 0) ? 1'b0 : 1'(($urandom_range(0, 1)));
      else inter = ($urandom_range(0, 11) != 0);
      send_layer_frame(tid, layer_t'(s), sw, inter, s == n_spatial - 1);
    end
  endtask

  task automatic random_phase(input layer_t t_val, input layer_t s_val,
                              input int unsigned quota, input bit gaps);
    int unsigned start_count;
    set_targets(t_val, s_val);
    sender_gaps   = gaps;
    receiver_gaps = gaps;
    start_count = packets_sent;
    while (packets_sent - start_count < quota) begin
      if ($urandom_range(0, 6) == 0) send_packet(random_packet());
      else send_picture($urandom_range(0, 7) == 0);
    end
  endtask

  // The receiver holds off for a long stretch while packets keep coming, so
  // both internal registers fill and the input stalls.
  task automatic test_backpressure();
    set_targets(3'd7, 3'd7);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    long_hold_req = 1'b1;
    for (int unsigned i = 0; i < 30; i++) send_packet(random_packet());
    drain_results();
  endtask

  task automatic test_random_traffic();
    random_phase(3'd7, 3'd7, 170, 1'b1);
    random_phase(3'd0, 3'd0, 140, 1'b1);
    random_phase(3'd7, 3'd0, 140, 1'b0);
    random_phase(3'd0, 3'd7, 140, 1'b1);
    random_phase(layer_t'($urandom_range(0, 7)), layer_t'($urandom_range(0, 7)), 140, 1'b1);
    random_phase(layer_t'($urandom_range(0, 7)), layer_t'($urandom_range(0, 7)), 140, 1'b1);
    // Final stretch runs without any idling on either side.
    random_phase(3'd3, 3'd2, 150, 1'b0);
    drain_results();
  endtask

  initial begin
    sel_state    = '{cur_temporal: '0, cur_spatial: '0, await_intra: 1'b1};
    tgt_temporal = '0;
    tgt_spatial  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_intra_wait();
    test_up_switch();
    test_down_switch();
    test_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: svc_layer_packet_selector.f
+incdir+design
design/svcsel_pkg.sv
design/svcsel_decide.sv
design/svc_layer_packet_selector.sv
design/svcsel_checker.sv
tb/testbench.sv
